/* rtl/core/lpx_pkg.sv */
`default_nettype none

package lpx_pkg;

    localparam int SAMPLES = 8;

    // header bytes
    localparam logic [7:0] SYNC0 = 8'h55;
    localparam logic [7:0] SYNC1 = 8'hAA;
    localparam logic [7:0] SYNC2 = 8'h03;
    localparam logic [7:0] SYNC3 = 8'h08;

    // byte positions inside a frame
    localparam logic [5:0] POS_SYNC1    = 6'd1;
    localparam logic [5:0] POS_SYNC2    = 6'd2;
    localparam logic [5:0] POS_SYNC3    = 6'd3;
    localparam logic [5:0] POS_START_LO = 6'd6;
    localparam logic [5:0] POS_START_HI = 6'd7;
    localparam logic [5:0] POS_SAMPLE0  = 6'd8;
    localparam logic [5:0] POS_SAMPLE_Z = 6'd31;
    localparam logic [5:0] POS_END_LO   = 6'd32;
    localparam logic [5:0] POS_END_HI   = 6'd33;
    localparam logic [5:0] POS_LAST     = 6'd35;

    // angle arithmetic, angles in 1/64 deg, points in 1/448 deg
    localparam logic [16:0]        ANGLE_OFFSET = 17'h0A000;
    localparam logic signed [17:0] TURN_64      = 18'sd23040;
    localparam logic signed [20:0] TURN_448     = 21'sd161280;
    localparam logic [23:0]        CENTI_SCALE  = 24'd100;
    localparam logic [23:0]        ROUND_HALF   = 24'd224;
    localparam logic [17:0]        DIV7_RECIP   = 18'd37449;  // floor(2^18 / 7)
    localparam logic [18:0]        SEVEN        = 19'd7;

    // configuration register indexes
    localparam logic CFG_MIN_DISTANCE = 1'b0;
    localparam logic CFG_MAX_DISTANCE = 1'b1;

    typedef struct packed {
        logic [15:0]               start_raw;
        logic [15:0]               end_raw;
        logic [SAMPLES-1:0][15:0]  dist_mm;
        logic [SAMPLES-1:0]        qual_ok;
    } frame_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INIT,
        ST_CHECK,
        ST_MOD,
        ST_SCALE,
        ST_RECIP,
        ST_FIX,
        ST_OUT,
        ST_NEXT
    } seq_state_t;

endpackage

`default_nettype wire

/* rtl/core/lpx_frame_rx.sv */
`default_nettype none

module lpx_frame_rx
    import lpx_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_accept,
    input  wire logic [7:0] rx_byte,
    output frame_t          frame,
    output logic            frame_done
);

    logic       hunting_reg, hunting_next;
    logic [5:0] count_reg, count_next;
    logic [2:0] slot_reg, slot_next;
    logic [1:0] phase_reg, phase_next;
    frame_t     frame_reg, frame_next;
    logic       mismatch;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunting_reg <= 1'b1;
            count_reg   <= '0;
            slot_reg    <= '0;
            phase_reg   <= '0;
        end
        else
        begin
            hunting_reg <= hunting_next;
            count_reg   <= count_next;
            slot_reg    <= slot_next;
            phase_reg   <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg <= frame_next;
    end

    always_comb
    begin
        hunting_next = hunting_reg;
        count_next   = count_reg;
        slot_next    = slot_reg;
        phase_next   = phase_reg;
        frame_next   = frame_reg;
        frame_done   = 1'b0;
        mismatch     = ((count_reg == POS_SYNC1) && (rx_byte != SYNC1)) ||
                       ((count_reg == POS_SYNC2) && (rx_byte != SYNC2)) ||
                       ((count_reg == POS_SYNC3) && (rx_byte != SYNC3));

        if (byte_accept)
        begin
            if (hunting_reg)
            begin
                if (rx_byte == SYNC0)
                begin
                    hunting_next = 1'b0;
                    count_next   = 6'd1;
                end
            end
            else
            begin
                count_next = count_reg + 6'd1;
                if (mismatch)
                begin
                    hunting_next = 1'b1;
                    count_next   = '0;
                end
                else if (count_reg == POS_LAST)
                begin
                    frame_done   = 1'b1;
                    hunting_next = 1'b1;
                    count_next   = '0;
                end

                case (count_reg)
                    POS_START_LO: frame_next.start_raw[7:0]  = rx_byte;
                    POS_START_HI:
                    begin
                        frame_next.start_raw[15:8] = rx_byte;
                        slot_next  = '0;
                        phase_next = '0;
                    end
                    POS_END_LO:   frame_next.end_raw[7:0]    = rx_byte;
                    POS_END_HI:   frame_next.end_raw[15:8]   = rx_byte;
                    default:      ;
                endcase

                // samples are distance low, distance high, quality
                if ((count_reg >= POS_SAMPLE0) && (count_reg <= POS_SAMPLE_Z))
                begin
                    case (phase_reg)
                        2'd0:
                        begin
                            frame_next.dist_mm[slot_reg][7:0] = rx_byte;
                            phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            frame_next.dist_mm[slot_reg][15:8] = rx_byte;
                            phase_next = 2'd2;
                        end
                        default:
                        begin
                            frame_next.qual_ok[slot_reg] = (rx_byte != 8'd0);
                            phase_next = 2'd0;
                            slot_next  = slot_reg + 3'd1;
                        end
                    endcase
                end
            end
        end
    end

    assign frame = frame_reg;

endmodule

`default_nettype wire

/* rtl/core/lpx_point_seq.sv */
`default_nettype none

module lpx_point_seq
    import lpx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frame_t      frame,
    input  wire logic        frame_done,
    input  wire logic [15:0] min_distance,
    input  wire logic [15:0] max_distance,
    output logic             busy,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      angle_centideg,
    output logic [15:0]      distance_mm,
    output logic [2:0]       sample_slot,
    output logic             last_point
);

    seq_state_t         state_reg, state_next;
    logic [2:0]         k_reg, k_next;
    logic [7:0]         mask_reg, mask_next;
    logic signed [20:0] acc_reg, acc_next;
    logic signed [17:0] diff_reg, diff_next;
    logic signed [20:0] r_reg, r_next;
    logic [17:0]        x_reg, x_next;
    logic [15:0]        q_reg, q_next;
    logic [15:0]        angle_reg, angle_next;
    logic [15:0]        dist_reg, dist_next;
    logic [2:0]         slot_reg, slot_next;
    logic               last_reg, last_next;

    logic signed [16:0] s_val, e_val;
    logic signed [20:0] s_ext;
    logic signed [17:0] e_adj;
    logic [23:0]        scaled;
    logic [33:0]        prod;
    logic [18:0]        rem;
    logic [7:0]         higher;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            k_reg     <= '0;
            mask_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            mask_reg  <= mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        diff_reg  <= diff_next;
        r_reg     <= r_next;
        x_reg     <= x_next;
        q_reg     <= q_next;
        angle_reg <= angle_next;
        dist_reg  <= dist_next;
        slot_reg  <= slot_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        mask_next  = mask_reg;
        acc_next   = acc_reg;
        diff_next  = diff_reg;
        r_next     = r_reg;
        x_next     = x_reg;
        q_next     = q_reg;
        angle_next = angle_reg;
        dist_next  = dist_reg;
        slot_next  = slot_reg;
        last_next  = last_reg;

        s_val  = 17'({1'b0, frame.start_raw} - ANGLE_OFFSET);
        e_val  = 17'({1'b0, frame.end_raw} - ANGLE_OFFSET);
        s_ext  = {{4{s_val[16]}}, s_val};
        e_adj  = {e_val[16], e_val};
        if (e_val < s_val)
        begin
            e_adj = e_adj + TURN_64;
        end
        scaled = 24'({6'd0, r_reg[17:0]} * CENTI_SCALE) + ROUND_HALF;
        prod   = 34'(x_reg * DIV7_RECIP);
        rem    = {1'b0, x_reg} - 19'({3'd0, q_reg} * SEVEN);
        higher = mask_reg >> k_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (frame_done)
                begin
                    state_next = ST_SCAN;
                    k_next     = '0;
                    mask_next  = '0;
                end
            end
            ST_SCAN:
            begin
                mask_next[k_reg] = (frame.dist_mm[k_reg] > min_distance) &&
                                   (frame.dist_mm[k_reg] < max_distance) &&
                                   frame.qual_ok[k_reg];
                k_next = k_reg + 3'd1;
                if (k_reg == 3'(SAMPLES - 1))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                // running angle starts at 7*s, grows by (e - s) per slot
                acc_next   = (s_ext <<< 3) - s_ext;
                diff_next  = e_adj - {s_val[16], s_val};
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (mask_reg[k_reg])
                begin
                    r_next     = acc_reg;
                    state_next = ST_MOD;
                end
                else
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_MOD:
            begin
                // fold into one turn, one add or subtract per cycle
                if (r_reg[20])
                begin
                    r_next = r_reg + TURN_448;
                end
                else if (r_reg >= TURN_448)
                begin
                    r_next = r_reg - TURN_448;
                end
                else
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                x_next     = scaled[23:6];
                state_next = ST_RECIP;
            end
            ST_RECIP:
            begin
                q_next     = prod[33:18];
                state_next = ST_FIX;
            end
            ST_FIX:
            begin
                // reciprocal estimate is low by at most one
                angle_next = (rem >= SEVEN) ? (q_reg + 16'd1) : q_reg;
                dist_next  = frame.dist_mm[k_reg];
                slot_next  = k_reg;
                // own bit is set here, so nothing valid above it means a one
                last_next  = (higher == 8'd1);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_stall)
                begin
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (k_reg == 3'(SAMPLES - 1))
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    acc_next   = acc_reg + {{3{diff_reg[17]}}, diff_reg};
                    k_next     = k_reg + 3'd1;
                    state_next = ST_CHECK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy           = (state_reg != ST_IDLE);
    assign out_valid      = (state_reg == ST_OUT);
    assign angle_centideg = angle_reg;
    assign distance_mm    = dist_reg;
    assign sample_slot    = slot_reg;
    assign last_point     = last_reg;

endmodule

`default_nettype wire

/* rtl/core/lidar_packet_point_extractor.sv */
`default_nettype none

// lidar packet point extractor: takes one serial byte per request, finds the
// 55 AA 03 08 header and gathers a 36-byte frame. While bytes are collected a
// request is taken every cycle. After the last byte of a frame the input stalls
// while one shared angle datapath walks the eight samples: it screens them
// against min/max distance and quality, skips each rejected sample and runs
// each emitted point through wrap, scale and divide by seven, holding it while
// the output is stalled.
module lidar_packet_point_extractor
    import lpx_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [15:0]      angle_centideg,
    output logic [15:0]      distance_mm,
    output logic [2:0]       sample_slot,
    output logic             last_point,
    input  wire logic        cfg_write,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    logic [15:0] min_dist_reg;
    logic [15:0] max_dist_reg;
    logic        byte_accept;
    logic        frame_done;
    logic        busy;
    frame_t      frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_dist_reg <= 16'd100;
            max_dist_reg <= 16'd12000;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_MIN_DISTANCE: min_dist_reg <= cfg_data;
                CFG_MAX_DISTANCE: max_dist_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign in_stall    = busy;
    assign byte_accept = in_valid && !busy;

    lpx_frame_rx u_frame_rx (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .frame       (frame),
        .frame_done  (frame_done)
    );

    lpx_point_seq u_point_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame          (frame),
        .frame_done     (frame_done),
        .min_distance   (min_dist_reg),
        .max_distance   (max_dist_reg),
        .busy           (busy),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .angle_centideg (angle_centideg),
        .distance_mm    (distance_mm),
        .sample_slot    (sample_slot),
        .last_point     (last_point)
    );

endmodule

`default_nettype wire
